### rtl/core/oli_pkg.sv
package oli_pkg;

    // Fixed field widths and id space
    localparam int ID_W     = 10;
    localparam int ID_LIMIT = 1024;

    // Operation codes
    localparam logic [1:0] FUNC_INS_LEFT  = 2'd0;
    localparam logic [1:0] FUNC_INS_RIGHT = 2'd1;
    localparam logic [1:0] FUNC_DELETE    = 2'd2;
    localparam logic [1:0] FUNC_READ      = 2'd3;

    // Result status codes
    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_ABSENT = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;
    localparam logic [1:0] STATUS_EMPTY  = 2'd3;

    // Classified command handed from front to back
    typedef struct packed {
        logic [1:0]      func;
        logic [ID_W-1:0] ref_id;
        logic            ref_ok;   // nonzero and inside the table
    } oli_cmd_t;

    typedef struct packed {
        logic [ID_W-1:0] item_id;
        logic [1:0]      status;
        logic            last_item;
    } oli_res_t;

endpackage

### rtl/core/ordered_list_insert_delete_core.sv
// Ordered list of numbered entries kept as a doubly linked list in two link
// RAMs (next and prev) plus a presence RAM. After reset the list holds entry
// 1. func 0/1 inserts the next sequential id left/right of ref_id and returns
// it, func 2 deletes ref_id, func 3 walks the list from the head one entry
// per transfer, marking the tail with last_item and wrapping afterwards.
// Errors come back as status (1 reference absent, 2 table full, 3 list empty)
// with item_id zero. Exactly one result per input transfer, in order. Both
// sides are queues: push/full in, empty/pop out, two slots each. The back
// engine handles one command at a time because each step reads links that
// the previous one may have written; the link RAMs have one write port, so
// an insert writes in S_WR1 and S_WR2. From S_EVAL an error result goes to
// S_PUSH, a delete via S_WR1, an insert via both write states, a read via
// S_READ2 (entry, then successor); S_PUSH waits for result-queue room.
// No clearing pass is needed after reset: ids are handed out in order, so
// presence is gated by the next free id, and entry 1 and the sentinel keep
// their reset links in flops until first written.
module ordered_list_insert_delete_core
    import oli_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic [1:0]      func,
    input  logic [ID_W-1:0] ref_id,
    output logic            empty,
    input  logic            pop,
    output logic [ID_W-1:0] item_id,
    output logic [1:0]      status,
    output logic            last_item
);

    logic     cmd_valid;
    logic     cmd_take;
    oli_cmd_t cmd;

    // front: accepts transfers, range-checks the reference, queues commands
    oli_front #(.MAX_ENTRIES(MAX_ENTRIES)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .func      (func),
        .ref_id    (ref_id),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // back: link RAM engine and result queue
    oli_back #(.MAX_ENTRIES(MAX_ENTRIES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .empty     (empty),
        .pop       (pop),
        .item_id   (item_id),
        .status    (status),
        .last_item (last_item)
    );

endmodule

### rtl/core/oli_ram.sv
module oli_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/core/oli_front.sv
module oli_front
    import oli_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  logic [1:0]      func,
    input  logic [ID_W-1:0] ref_id,
    output logic            cmd_valid,
    output oli_cmd_t        cmd,
    input  logic            cmd_take
);

    localparam int DEPTH = (MAX_ENTRIES < ID_LIMIT) ? MAX_ENTRIES : ID_LIMIT;

    oli_cmd_t   q_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    oli_cmd_t   new_cmd;
    logic       push_ok, take_ok;

    // classify on the way in: range check of the reference
    always_comb
    begin
        new_cmd.func   = func;
        new_cmd.ref_id = ref_id;
        new_cmd.ref_ok = (ref_id != '0) && ({1'b0, ref_id} < (ID_W + 1)'(DEPTH));
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push_ok   = push && !full;
    assign take_ok   = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = push_ok ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = take_ok ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, push_ok} - {1'b0, take_ok};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

### rtl/core/oli_back.sv
module oli_back
    import oli_pkg::*;
#(
    parameter int MAX_ENTRIES = 1024
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    input  oli_cmd_t        cmd,
    output logic            cmd_take,
    output logic            empty,
    input  logic            pop,
    output logic [ID_W-1:0] item_id,
    output logic [1:0]      status,
    output logic            last_item
);

    localparam int DEPTH = (MAX_ENTRIES < ID_LIMIT) ? MAX_ENTRIES : ID_LIMIT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_READ2 = 3'd2;
    localparam logic [2:0] S_WR1   = 3'd3;
    localparam logic [2:0] S_WR2   = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;

    logic [2:0]    state_reg, state_next;
    oli_cmd_t      cmd_reg, cmd_next;
    logic [AW-1:0] left_reg, left_next;
    logic [AW-1:0] right_reg, right_next;
    logic [AW-1:0] id_reg, id_next;
    logic [AW-1:0] nrd_addr_reg, nrd_addr_next;
    oli_res_t      res_reg, res_next;
    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] read_pos_reg, read_pos_next;
    logic [AW:0]   nni_reg, nni_next;
    logic          next1_wr_reg, next1_wr_next;
    logic          prev1_wr_reg, prev1_wr_next;
    logic          pres1_wr_reg, pres1_wr_next;

    logic          next_we, prev_we, pres_we;
    logic [AW-1:0] next_waddr, prev_waddr, pres_waddr;
    logic [AW-1:0] next_wdata, prev_wdata;
    logic          pres_wdata;
    logic [AW-1:0] next_raddr, prev_raddr, pres_raddr;
    logic [AW-1:0] next_q, prev_q;
    logic          pres_q;

    logic [AW-1:0] ref_a;
    logic [AW-1:0] next_rd, prev_rd, first_id, cand_id;
    logic          pres_rd, present;

    oli_res_t      oq_reg [2];
    logic          oq_wr_reg, oq_rd_reg;
    logic [1:0]    oq_cnt_reg;
    logic          oq_full, res_push, pop_ok;

    oli_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (next_raddr),
        .rdata (next_q)
    );

    oli_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (prev_raddr),
        .rdata (prev_q)
    );

    oli_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_pres_ram (
        .clk   (clk),
        .we    (pres_we),
        .waddr (pres_waddr),
        .wdata (pres_wdata),
        .raddr (pres_raddr),
        .rdata (pres_q)
    );

    // Entry 1 reads its reset contents until first written; slot 0's next
    // link lives in head_reg. Other entries are only read once written.
    assign ref_a   = cmd_reg.ref_id[AW-1:0];
    assign next_rd = (nrd_addr_reg == AW'(1) && !next1_wr_reg) ? '0 : next_q;
    assign prev_rd = (ref_a == AW'(1) && !prev1_wr_reg) ? '0 : prev_q;
    assign pres_rd = (ref_a == AW'(1) && !pres1_wr_reg) ? 1'b1 : pres_q;
    assign present = cmd_reg.ref_ok && ({1'b0, ref_a} < nni_reg) && pres_rd;

    assign first_id = (read_pos_reg == '0) ? head_reg : next_rd;
    assign cand_id  = (first_id == '0) ? head_reg : first_id;

    assign oq_full = (oq_cnt_reg == 2'd2);

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        left_next     = left_reg;
        right_next    = right_reg;
        id_next       = id_reg;
        nrd_addr_next = nrd_addr_reg;
        res_next      = res_reg;
        read_pos_next = read_pos_reg;
        nni_next      = nni_reg;
        cmd_take      = 1'b0;
        res_push      = 1'b0;

        next_we    = 1'b0;
        prev_we    = 1'b0;
        pres_we    = 1'b0;
        next_waddr = left_reg;
        next_wdata = id_reg;
        prev_waddr = right_reg;
        prev_wdata = id_reg;
        pres_waddr = id_reg;
        pres_wdata = 1'b1;

        next_raddr = (cmd.func == FUNC_READ) ? read_pos_reg : cmd.ref_id[AW-1:0];
        prev_raddr = cmd.ref_id[AW-1:0];
        pres_raddr = cmd.ref_id[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_take      = 1'b1;
                    cmd_next      = cmd;
                    nrd_addr_next = next_raddr;
                    state_next    = S_EVAL;
                end
            end
            S_EVAL:
            begin
                unique case (cmd_reg.func)
                    FUNC_INS_LEFT, FUNC_INS_RIGHT:
                    begin
                        if (!present)
                        begin
                            res_next   = '{item_id: '0, status: STATUS_ABSENT, last_item: 1'b0};
                            state_next = S_PUSH;
                        end
                        else if (nni_reg == (AW + 1)'(DEPTH))
                        begin
                            res_next   = '{item_id: '0, status: STATUS_FULL, last_item: 1'b0};
                            state_next = S_PUSH;
                        end
                        else
                        begin
                            id_next = nni_reg[AW-1:0];
                            if (cmd_reg.func == FUNC_INS_LEFT)
                            begin
                                left_next  = prev_rd;
                                right_next = ref_a;
                            end
                            else
                            begin
                                left_next  = ref_a;
                                right_next = next_rd;
                            end
                            state_next = S_WR1;
                        end
                    end
                    FUNC_DELETE:
                    begin
                        if (!present)
                        begin
                            res_next   = '{item_id: '0, status: STATUS_ABSENT, last_item: 1'b0};
                            state_next = S_PUSH;
                        end
                        else
                        begin
                            left_next  = prev_rd;
                            right_next = next_rd;
                            state_next = S_WR1;
                        end
                    end
                    FUNC_READ:
                    begin
                        if (cand_id == '0)
                        begin
                            read_pos_next = '0;
                            res_next   = '{item_id: '0, status: STATUS_EMPTY, last_item: 1'b0};
                            state_next = S_PUSH;
                        end
                        else
                        begin
                            // second lookup tells whether this is the tail
                            id_next       = cand_id;
                            next_raddr    = cand_id;
                            nrd_addr_next = cand_id;
                            state_next    = S_READ2;
                        end
                    end
                endcase
            end
            S_READ2:
            begin
                read_pos_next = (next_rd == '0) ? '0 : id_reg;
                res_next      = '{item_id: ID_W'(id_reg), status: STATUS_OK,
                                  last_item: (next_rd == '0)};
                state_next    = S_PUSH;
            end
            S_WR1:
            begin
                next_we = 1'b1;
                prev_we = 1'b1;
                pres_we = 1'b1;
                if (cmd_reg.func == FUNC_DELETE)
                begin
                    next_wdata = right_reg;
                    prev_wdata = left_reg;
                    pres_waddr = ref_a;
                    pres_wdata = 1'b0;
                    if (read_pos_reg == ref_a)
                    begin
                        read_pos_next = left_reg;
                    end
                    res_next   = '{item_id: '0, status: STATUS_OK, last_item: 1'b0};
                    state_next = S_PUSH;
                end
                else
                begin
                    state_next = S_WR2;
                end
            end
            S_WR2:
            begin
                next_we    = 1'b1;
                prev_we    = 1'b1;
                next_waddr = id_reg;
                next_wdata = right_reg;
                prev_waddr = id_reg;
                prev_wdata = left_reg;
                nni_next   = nni_reg + (AW + 1)'(1);
                res_next   = '{item_id: ID_W'(id_reg), status: STATUS_OK, last_item: 1'b0};
                state_next = S_PUSH;
            end
            S_PUSH:
            begin
                if (!oq_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // shadow of the sentinel's next link and first-write marks of entry 1
    always_comb
    begin
        head_next     = (next_we && next_waddr == '0) ? next_wdata : head_reg;
        next1_wr_next = next1_wr_reg || (next_we && next_waddr == AW'(1));
        prev1_wr_next = prev1_wr_reg || (prev_we && prev_waddr == AW'(1));
        pres1_wr_next = pres1_wr_reg || (pres_we && pres_waddr == AW'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= AW'(1);
            read_pos_reg <= '0;
            nni_reg      <= (AW + 1)'(2);
            next1_wr_reg <= 1'b0;
            prev1_wr_reg <= 1'b0;
            pres1_wr_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            read_pos_reg <= read_pos_next;
            nni_reg      <= nni_next;
            next1_wr_reg <= next1_wr_next;
            prev1_wr_reg <= prev1_wr_next;
            pres1_wr_reg <= pres1_wr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        left_reg     <= left_next;
        right_reg    <= right_next;
        id_reg       <= id_next;
        nrd_addr_reg <= nrd_addr_next;
        res_reg      <= res_next;
    end

    // two-entry result queue
    assign pop_ok    = pop && !empty;
    assign empty     = (oq_cnt_reg == 2'd0);
    assign item_id   = oq_reg[oq_rd_reg].item_id;
    assign status    = oq_reg[oq_rd_reg].status;
    assign last_item = oq_reg[oq_rd_reg].last_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= 1'b0;
            oq_rd_reg  <= 1'b0;
            oq_cnt_reg <= 2'd0;
        end
        else
        begin
            if (res_push)
            begin
                oq_wr_reg <= !oq_wr_reg;
            end
            if (pop_ok)
            begin
                oq_rd_reg <= !oq_rd_reg;
            end
            oq_cnt_reg <= oq_cnt_reg + {1'b0, res_push} - {1'b0, pop_ok};
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            oq_reg[oq_wr_reg] <= res_reg;
        end
    end

endmodule

### rtl/core/oli_checker.sv
module oli_checker
    import oli_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            empty,
    input logic            pop,
    input logic [ID_W-1:0] item_id,
    input logic [1:0]      status,
    input logic            last_item
);

    // a reset edge leaves nothing waiting on the result side
    assert property (@(posedge clk) !rst_n |=> empty)
        else $error("result queue not empty after reset");

    // a waiting result holds until transferred
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(item_id) && $stable(status)
                              && $stable(last_item)))
        else $error("waiting result changed");

    // any error result carries no id and no tail mark
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != STATUS_OK) |-> (item_id == '0 && !last_item))
        else $error("error result with id or tail mark");

    // a tail mark comes only with a real entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last_item) |-> (status == STATUS_OK && item_id != '0))
        else $error("tail mark without entry");

endmodule

bind ordered_list_insert_delete_core oli_checker u_oli_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .empty     (empty),
    .pop       (pop),
    .item_id   (item_id),
    .status    (status),
    .last_item (last_item)
);
